/* src/lmrs_pkg.sv */
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants of the LED matrix row scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

	localparam int ROW_W   = 3;
	localparam int PAT_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int FRAME_W = 4 * BYTE_W;
	localparam int CNT_W   = $clog2(FRAME_W);

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_W - 1);
	localparam logic [2:0]       BYTE_END = 3'd7;
	localparam logic [BYTE_W-1:0] ROW_ONE = 8'b0000_0001;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// access to the frame store
	typedef struct packed {
		logic             we;
		logic             re;
		logic [ROW_W-1:0] addr;
		logic [PAT_W-1:0] wdata;
	} store_req_t;

	// tick waiting for the serializer: scan row and its pattern
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [PAT_W-1:0] data;
	} pend_t;

endpackage

/* src/lmrs_in_if.sv */
// ----------------------------------------------------------------------------
// lmrs_in_if
// Input channel: write and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmrs_in_if;
	import lmrs_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [ROW_W-1:0] row_select;
	logic [PAT_W-1:0] row_pattern;

	modport source (output valid, op, row_select, row_pattern, input ready);
	modport sink   (input valid, op, row_select, row_pattern, output ready);
endinterface

/* src/lmrs_out_if.sv */
// ----------------------------------------------------------------------------
// lmrs_out_if
// Output channel: one serial bit per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmrs_out_if;
	logic valid;
	logic ready;
	logic serial_bit;
	logic latch_strobe;
	logic last_bit;

	modport source (output valid, serial_bit, latch_strobe, last_bit, input ready);
	modport sink   (input valid, serial_bit, latch_strobe, last_bit, output ready);
endinterface

/* src/lmrs_frame_store.sv */
// ----------------------------------------------------------------------------
// lmrs_frame_store
// Row pattern memory with registered read and per-row valid bits.
// ----------------------------------------------------------------------------
module lmrs_frame_store
	import lmrs_pkg::*;
#(
	parameter int ROWS    = 8,
	parameter int COLUMNS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  store_req_t       req,
	output logic [PAT_W-1:0] rdata
);

	localparam int IDX_W = $clog2(ROWS);

	logic [COLUMNS-1:0] mem [ROWS];
	logic [ROWS-1:0]    valid_q;
	logic [COLUMNS-1:0] rd_data_q;
	logic               rd_valid_q;

	wire [IDX_W-1:0] idx = req.addr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[idx] <= req.wdata[COLUMNS-1:0];
		end
		if (req.re) begin
			rd_data_q <= mem[idx];
		end
	end

	// rows never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[idx] <= 1'b1;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[idx];
			end
		end
	end

	assign rdata = rd_valid_q ? PAT_W'(rd_data_q) : '0;

endmodule

/* src/lmrs_serializer.sv */
// ----------------------------------------------------------------------------
// lmrs_serializer
// Builds the 32-bit frame of one tick and shifts it out one bit per beat.
// ----------------------------------------------------------------------------
module lmrs_serializer
	import lmrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pend_t       pend,
	output logic        take,
	lmrs_out_if.source  out_ch
);

	logic [FRAME_W-1:0] sr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [BYTE_W-1:0]  mask;
	logic [FRAME_W-1:0] frame;
	logic               fire;
	logic               last;

	assign mask  = ~(ROW_ONE << pend.row);
	assign frame = {pend.data[PAT_W-1:BYTE_W], mask, pend.data[BYTE_W-1:0], mask};

	assign fire = busy_q && out_ch.ready;
	assign last = (cnt_q == LAST_CNT);
	assign take = pend.valid && (!busy_q || (fire && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (fire) begin
			busy_q <= !last;
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sr_q <= frame;
		end else if (fire) begin
			sr_q <= {sr_q[FRAME_W-2:0], 1'b0};
		end
	end

	assign out_ch.valid        = busy_q;
	assign out_ch.serial_bit   = sr_q[FRAME_W-1];
	assign out_ch.latch_strobe = (cnt_q[2:0] == BYTE_END);
	assign out_ch.last_bit     = last;

endmodule

/* src/led_matrix_row_scanner.sv */
// ----------------------------------------------------------------------------
// led_matrix_row_scanner
// Scans a ROWS x COLUMNS LED matrix through a daisy-chained shift register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries items. op = write stores row_pattern for row_select in the
//   frame store (rows at or above ROWS are dropped); op = tick sends the
//   current scan row and advances it, wrapping after row ROWS-1.
//   out_ch carries one serial bit per beat: 32 beats per tick, MSB first,
//   as high pattern byte, inverted row mask, low pattern byte, inverted mask.
//   latch_strobe marks the eighth bit of each byte, last_bit the 32nd.
// Flow:
//   A write is stored at its accept edge. A tick reads the frame store at
//   its accept edge into stage 1, is loaded into the shift register when
//   the serializer is free and then goes out one bit per cycle while
//   out_ch.ready is high. Writes flow during a frame while stage 1 is empty;
//   a second tick waits there, holding in_ch.ready low until it is taken.
// Reset:
//   arst_n clears the row valid bits (all rows read as zero), the scan row
//   and the serializer. out_ch.ready low holds the current bit; a second tick
//   then waits in stage 1 and in_ch.ready drops until the shifter frees up.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner
	import lmrs_pkg::*;
#(
	parameter int ROWS    = 8,
	parameter int COLUMNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lmrs_in_if.sink    in_ch,
	lmrs_out_if.source out_ch
);

	localparam int IDX_W = $clog2(ROWS);
	localparam logic [ROW_W:0]   ROWS_L   = (ROW_W + 1)'(ROWS);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ROWS - 1);

	logic [IDX_W-1:0] scan_row_q;
	logic             tick_s1;
	logic [ROW_W-1:0] row_s1;
	logic [PAT_W-1:0] rdata;
	store_req_t       req;
	pend_t            pend;
	logic             take;
	logic             acc;
	logic             is_tick;

	// stage 1 frees up when its tick moves into the serializer
	assign in_ch.ready = !tick_s1 || take;
	assign acc         = in_ch.valid && in_ch.ready;
	assign is_tick     = (op_t'(in_ch.op) == OP_TICK);

	// write at the item's own row, read the scan row on a tick
	always_comb begin
		req.we    = acc && !is_tick && ({1'b0, in_ch.row_select} < ROWS_L);
		req.re    = acc && is_tick;
		req.addr  = is_tick ? ROW_W'(scan_row_q) : in_ch.row_select;
		req.wdata = in_ch.row_pattern;
	end

	lmrs_frame_store #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	// advance the scan row on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			tick_s1    <= 1'b0;
		end else begin
			if (req.re) begin
				scan_row_q <= (scan_row_q == LAST_ROW) ? '0 : scan_row_q + IDX_W'(1);
			end
			if (req.re) begin
				tick_s1 <= 1'b1;
			end else if (take) begin
				tick_s1 <= 1'b0;
			end
		end
	end

	// hold the row of the pending tick alongside the registered read data
	always_ff @(posedge clk) begin
		if (req.re) begin
			row_s1 <= ROW_W'(scan_row_q);
		end
	end

	always_comb begin
		pend.valid = tick_s1;
		pend.row   = row_s1;
		pend.data  = rdata;
	end

	lmrs_serializer u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.pend   (pend),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule
